### hw/rtl/bss_pkg.sv
package bss_pkg;

  // Entry store
  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Field widths
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int COUNT_W = 5;
  localparam int OUT_W   = 8;

  // Width for comparing the entry count against the capacity
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } bss_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CMP,
    ST_DECIDE,
    ST_SH_RD,
    ST_SH_WR,
    ST_PLACE,
    ST_DONE
  } bss_state_t;

endpackage

### hw/rtl/bss_ram.sv
module bss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/bounded_sorted_set.sv
// Bounded sorted set: holds distinct signed 32-bit values in ascending order,
// at most min(capacity, 16) of them. Each input beat carries a command on
// s_axis_tuser (0 insert, 1 delete) and a value on s_axis_tdata; each command
// returns exactly one output beat with ok, the new count and the empty and
// full flags. A duplicate insert, an insert into a full set, and a delete of
// an absent value are refused with ok low and the state untouched. Lowering
// capacity below the current count drops nothing; the set simply reads full
// until enough deletes bring it under. The values sit in a single-port-write,
// registered-read RAM that one compare unit walks under a small sequencer:
// the search passes through SEARCH and CMP for each entry below the value,
// and each entry moved by an insert or delete passes through SH_RD and SH_WR.
// The block takes no new beat while a command is in progress, but it will
// start the next command while the previous result is still waiting in the
// output register. Capacity is written through cfg_wr_en/cfg_wr_data; the
// user must write it only while the block is idle, as the block itself does
// not enforce this; it resets to 16.
module bounded_sorted_set (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [bss_pkg::CAP_W-1:0]     cfg_wr_data,   // capacity
  // command stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bss_pkg::VAL_W-1:0]     s_axis_tdata,  // [31:0] value
  input  logic                          s_axis_tuser,  // [0] cmd
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bss_pkg::OUT_W-1:0]     m_axis_tdata   // [0] ok, [5:1] count,
                                                       // [6] is_empty, [7] is_full
);

  import bss_pkg::*;

  bss_state_t state, state_next;

  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] pos;
  bss_cmd_t         cmd;
  logic [VAL_W-1:0] val;
  logic             found;
  logic             ok;

  // output register
  logic               m_valid;
  logic               m_ok;
  logic [COUNT_W-1:0] m_count;
  logic               m_empty;
  logic               m_full;

  // RAM port
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [VAL_W-1:0]  rdata;

  // derived
  logic [CMP_W-1:0]         used_ext;
  logic [CMP_W-1:0]         cap_eff;
  logic                     full;
  logic                     is_less;
  logic                     is_equal;
  logic [CNT_W-1:0]         idx_inc;
  logic [CNT_W-1:0]         idx_dec;
  logic                     scan_end;
  logic                     shift_done;
  logic                     out_free;
  logic [CNT_W+COUNT_W-1:0] count_wide;

  bss_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Capacity above the store depth is clamped; full once used reaches it.
  assign used_ext = CMP_W'(used);
  assign cap_eff  = (CMP_W'(capacity) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(capacity);
  assign full     = (used_ext >= cap_eff);

  // Shared compare unit: entry just read against the command value.
  assign is_less  = ($signed(rdata) < $signed(val));
  assign is_equal = (rdata == val);

  assign idx_inc  = idx + CNT_W'(1);
  assign idx_dec  = idx - CNT_W'(1);
  assign scan_end = (idx == used);

  // Insert moves entries up from the top down to pos; delete moves them
  // down from pos towards the top.
  assign shift_done = (cmd == CMD_INSERT) ? (idx == pos) : (idx_inc >= used);

  assign out_free   = !m_valid || m_axis_tready;
  assign count_wide = {{COUNT_W{1'b0}}, used};

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        state_next = scan_end ? ST_DECIDE : ST_CMP;
      end
      ST_CMP: begin
        state_next = is_less ? ST_SEARCH : ST_DECIDE;
      end
      ST_DECIDE: begin
        if (cmd == CMD_INSERT) begin
          state_next = (full || found) ? ST_DONE : ST_SH_RD;
        end else begin
          state_next = found ? ST_SH_RD : ST_DONE;
        end
      end
      ST_SH_RD: begin
        state_next = shift_done ? ST_PLACE : ST_SH_WR;
      end
      ST_SH_WR: begin
        state_next = ST_SH_RD;
      end
      ST_PLACE: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = idx[ADDR_W-1:0];
    ram_we        = 1'b0;
    ram_waddr     = idx[ADDR_W-1:0];
    ram_wdata     = rdata;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_SEARCH: begin
        ram_re    = !scan_end;
        ram_raddr = idx[ADDR_W-1:0];
      end
      ST_SH_RD: begin
        ram_re    = !shift_done;
        ram_raddr = (cmd == CMD_INSERT) ? idx_dec[ADDR_W-1:0] : idx_inc[ADDR_W-1:0];
      end
      ST_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx[ADDR_W-1:0];
        ram_wdata = rdata;
      end
      ST_PLACE: begin
        ram_we    = (cmd == CMD_INSERT);
        ram_waddr = pos[ADDR_W-1:0];
        ram_wdata = val;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      capacity <= CAP_RESET;
      used     <= '0;
      m_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end

      // drop the result once taken; in ST_DONE the new result replaces it
      if (m_valid && m_axis_tready && (state != ST_DONE)) begin
        m_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd <= bss_cmd_t'(s_axis_tuser);
            val <= s_axis_tdata;
            idx <= '0;
            ok  <= 1'b0;
          end
        end
        ST_SEARCH: begin
          // ran past the last entry: the value is not held
          if (scan_end) begin
            found <= 1'b0;
          end
        end
        ST_CMP: begin
          if (is_less) begin
            idx <= idx_inc;
          end else begin
            found <= is_equal;
          end
        end
        ST_DECIDE: begin
          pos <= idx;
          // insert shifts from the top slot downwards
          if (cmd == CMD_INSERT) begin
            idx <= used;
          end
        end
        ST_SH_WR: begin
          idx <= (cmd == CMD_INSERT) ? idx_dec : idx_inc;
        end
        ST_PLACE: begin
          ok   <= 1'b1;
          used <= (cmd == CMD_INSERT) ? (used + CNT_W'(1)) : (used - CNT_W'(1));
        end
        ST_DONE: begin
          if (out_free) begin
            m_valid <= 1'b1;
            m_ok    <= ok;
            m_count <= count_wide[COUNT_W-1:0];
            m_empty <= (used == '0);
            m_full  <= full;
          end
        end
        default: begin
          idx <= idx;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {m_full, m_empty, m_count, m_ok};

endmodule

### hw/rtl/bss_checker.sv
module bss_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      cfg_wr_en,
  input logic [bss_pkg::CAP_W-1:0] cfg_wr_data,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [bss_pkg::VAL_W-1:0] s_axis_tdata,
  input logic                      s_axis_tuser,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [bss_pkg::OUT_W-1:0] m_axis_tdata
);

  import bss_pkg::*;

  // No result may be pending straight after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Empty flag agrees with the count.
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[6] == (m_axis_tdata[5:1] == 5'd0)))
    else $error("is_empty disagrees with count");

  // A command keeps the input side busy for the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready straight after a command beat");

endmodule

bind bounded_sorted_set bss_checker u_bss_checker (.*);

### sim/bounded_sorted_set_checker.sv
module bounded_sorted_set_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [bss_pkg::CAP_W-1:0] cfg_wr_data,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [bss_pkg::VAL_W-1:0] s_axis_tdata,   // [31:0] value
  input  logic                      s_axis_tuser,   // [0] cmd
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [bss_pkg::OUT_W-1:0] m_axis_tdata,   // [0] ok, [5:1] count,
                                                    // [6] is_empty, [7] is_full
  output int                        mismatches,
  output int                        replies_owed
);

  import bss_pkg::*;

  typedef struct packed {
    logic               is_full;
    logic               is_empty;
    logic [COUNT_W-1:0] count;
    logic               ok;
  } set_reply_t;

  logic signed [VAL_W-1:0] held_values[$];      // mirror of the set, ascending
  set_reply_t              expected_replies[$];
  logic [CAP_W-1:0]        capacity;
  int                      replies_seen;

  function automatic int capacity_limit(logic [CAP_W-1:0] cap);
    return (int'(cap) > DEPTH) ? DEPTH : int'(cap);
  endfunction

  // Apply one command to the mirror and return the reply it must produce.
  function automatic set_reply_t apply_command(bss_cmd_t cmd, logic signed [VAL_W-1:0] value);
    set_reply_t reply;
    int         slot;
    int         limit;
    slot     = 0;
    limit    = capacity_limit(capacity);
    reply.ok = 1'b0;
    while (slot < held_values.size() && held_values[slot] < value)
      slot++;
    if (cmd == CMD_INSERT) begin
      if (held_values.size() < limit &&
          !(slot < held_values.size() && held_values[slot] == value)) begin
        held_values.insert(slot, value);
        reply.ok = 1'b1;
      end
    end else if (slot < held_values.size() && held_values[slot] == value) begin
      held_values.delete(slot);
      reply.ok = 1'b1;
    end
    reply.count    = COUNT_W'(held_values.size());
    reply.is_empty = (held_values.size() == 0);
    reply.is_full  = (held_values.size() >= limit);
    return reply;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] reply %0d: %s", $time, replies_seen, msg);
  endtask

  always @(posedge clk) begin
    set_reply_t got;
    set_reply_t want;
    if (rst) begin
      held_values.delete();
      expected_replies.delete();
      capacity = CAP_RESET;
    end else begin
      if (cfg_wr_en)
        capacity = cfg_wr_data;
      // Retire the reply before taking the new command: it belongs to an older one.
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        replies_seen++;
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("reply %h with no command outstanding", got));
        end else begin
          want = expected_replies.pop_front();
          if (got.ok !== want.ok)
            report_mismatch($sformatf("ok %b, expected %b", got.ok, want.ok));
          if (got.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
          if (got.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty %b, expected %b",
                                      got.is_empty, want.is_empty));
          if (got.is_full !== want.is_full)
            report_mismatch($sformatf("is_full %b, expected %b",
                                      got.is_full, want.is_full));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_replies.push_back(apply_command(bss_cmd_t'(s_axis_tuser),
                                                 $signed(s_axis_tdata)));
    end
    replies_owed = expected_replies.size();
  end

endmodule

### sim/bounded_sorted_set_tb.sv
module bounded_sorted_set_tb;

  import bss_pkg::*;

  localparam int HOLD_CYCLES = 400;   // long receiver stall to fill the block
  localparam int PHASE_BEATS = 120;
  localparam int PHASES      = 12;
  localparam int POOL_SIZE   = 24;
  localparam int TAIL_CYCLES = 60;    // roughly one full-set command and margin

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [CAP_W-1:0]    cfg_wr_data;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [VAL_W-1:0]    s_axis_tdata;   // [31:0] value
  logic                s_axis_tuser;   // [0] cmd
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;   // [0] ok, [5:1] count, [6] is_empty, [7] is_full

  int                  mismatches;
  int                  replies_owed;

  // Idling switches; both sides idle by default, a quiet phase turns them off.
  bit                  send_idles = 1'b1;
  bit                  recv_idles = 1'b1;
  // One-shot long receiver stall: raised by the stimulus, served by the receiver.
  bit                  hold_req   = 1'b0;
  bit                  hold_done  = 1'b0;

  // Values reused within a phase so that duplicates and hits on delete are common.
  logic [VAL_W-1:0]    value_pool[POOL_SIZE];

  bounded_sorted_set i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bounded_sorted_set_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .replies_owed  (replies_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one command beat. Entered and left at a falling edge; valid stays
  // high on exit so that back-to-back beats need no second assignment.
  task automatic send_command(bss_cmd_t cmd, logic [VAL_W-1:0] value);
    while (send_idles && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every reply owed has come back.
  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    wait (replies_owed == 0);
    @(negedge clk);
  endtask

  // Write capacity only with the block idle.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain_replies();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Refill the pool: the signed extremes, a cluster round zero and random words.
  task automatic refresh_pool();
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 12; i++)
      value_pool[i] = VAL_W'($urandom_range(20)) - VAL_W'(10);
    for (int i = 12; i < POOL_SIZE; i++)
      value_pool[i] = $urandom;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(99) < 75)
      return value_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // One phase of random commands with a bias towards inserts or deletes.
  task automatic run_phase(int beats, int insert_pct);
    bss_cmd_t cmd;
    for (int n = 0; n < beats; n++) begin
      cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_DELETE;
      send_command(cmd, pick_value());
    end
  endtask

  // Receiver: random back-pressure, plus the one long stall on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      if (recv_idles)
        m_axis_tready <= ($urandom_range(99) >= 8);
      else
        m_axis_tready <= 1'b1;
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [CAP_W-1:0] phase_caps[PHASES];
    int               phase_insert_pct[PHASES];

    phase_caps       = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd5, 5'd16,
                         5'd0, 5'd2, 5'd16, 5'd12, 5'd31, 5'd0};
    phase_insert_pct = '{80, 55, 60, 50, 70, 85, 50, 40, 75, 30, 65, 20};

    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_INSERT;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, capacity at its reset value.
    send_command(CMD_DELETE, 32'h0000_0000);   // delete from an empty set
    send_command(CMD_INSERT, 32'h0000_0000);
    send_command(CMD_INSERT, 32'h8000_0000);   // most negative goes to the front
    send_command(CMD_INSERT, 32'h7fff_ffff);   // most positive goes to the back
    send_command(CMD_INSERT, 32'hffff_ffff);
    send_command(CMD_INSERT, 32'h0000_0001);
    send_command(CMD_INSERT, 32'h8000_0000);   // duplicate at the front
    send_command(CMD_INSERT, 32'h7fff_ffff);   // duplicate at the back
    send_command(CMD_DELETE, 32'h0000_0005);   // absent value

    // Lower capacity under the count: nothing dropped, set reads full.
    write_capacity(5'd2);
    send_command(CMD_INSERT, 32'h0000_0002);
    send_command(CMD_DELETE, 32'h7fff_ffff);
    send_command(CMD_DELETE, 32'h8000_0000);
    send_command(CMD_DELETE, 32'hffff_ffff);
    send_command(CMD_DELETE, 32'h0000_0000);

    // Zero capacity: every insert refused, an empty set still reads full.
    write_capacity(5'd0);
    send_command(CMD_INSERT, 32'h5555_5555);
    send_command(CMD_DELETE, 32'h0000_0001);

    // Capacity above the store depth: clamp to it.
    write_capacity(5'd31);
    send_command(CMD_INSERT, 32'haaaa_aaaa);
    send_command(CMD_INSERT, 32'h5555_5555);
    send_command(CMD_DELETE, 32'h5555_5555);

    // Random phases; the set carries over, so capacity often lands below the count.
    for (int p = 0; p < PHASES; p++) begin
      write_capacity((p == 6) ? CAP_W'($urandom_range(31)) : phase_caps[p]);
      refresh_pool();
      send_idles = (p != 5);
      recv_idles = (p != 5);
      if (p == 8)
        hold_req = 1'b1;
      run_phase(PHASE_BEATS, phase_insert_pct[p]);
    end

    drain_replies();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("bounded_sorted_set regression: pass");
    else
      $display("bounded_sorted_set regression: fail");
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("bounded_sorted_set regression: fail");
    $finish;
  end

endmodule

### sim.f
hw/rtl/bss_pkg.sv
hw/rtl/bss_ram.sv
hw/rtl/bounded_sorted_set.sv
hw/rtl/bss_checker.sv
sim/bounded_sorted_set_checker.sv
sim/bounded_sorted_set_tb.sv
